### hdl/clfco_pkg.sv
// package: shared types, codes and ramp helper for the contour overlay
`timescale 1ns / 1ps
`default_nettype none
package clfco_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LUMA_GAIN    = 3'd2;
    localparam logic [2:0] REG_LEVEL_COUNT  = 3'd3;
    localparam logic [2:0] REG_ZERO_GRID    = 3'd4;

    localparam int CFG_BITS  = 24;
    localparam int CODE_BITS = 27;
    localparam int LVL_BITS  = 10;
    localparam int ROW_BITS  = 13;
    localparam int NORM_BITS = 17;

    // center entry layout
    localparam int CEN_COV  = 26;
    localparam int CEN_DARK = 25;
    // level entry layout
    localparam int LV_COV   = 9;
    localparam int LV_DARK  = 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_LVL,
        S_EVAL,
        S_GRID
    } t_state;

    typedef struct packed {
        logic done;
        logic zero_a;
        logic zero_b;
    } t_grid_res;

    // ramp stops in units of 1/4 (Q0.16 value / 16384)
    typedef logic [2:0] t_stop [0:4][0:2];
    localparam t_stop RAMP_STOPS = '{
        '{3'd2, 3'd0, 3'd2},
        '{3'd0, 3'd0, 3'd2},
        '{3'd0, 3'd3, 3'd0},
        '{3'd4, 3'd4, 3'd0},
        '{3'd4, 3'd0, 3'd0}
    };

    // one ramp channel in Q0.16 for a norm value
    function automatic logic [16:0] ramp_chan(input logic [16:0] v, input int k);
        logic [17:0] t;
        logic [1:0]  seg;
        logic [16:0] f;
        logic [19:0] acc;
        begin
            t   = {v[15:0], 2'b00};
            seg = t[17:16];
            f   = {1'b0, t[15:0]};
            acc = 20'(RAMP_STOPS[seg][k]) * 20'(17'h10000 - f)
                + 20'(RAMP_STOPS[3'(seg) + 3'd1][k]) * 20'(f);
            if (v == 17'd0) begin
                ramp_chan = {RAMP_STOPS[0][k], 14'd0};
            end else if (v[16]) begin
                ramp_chan = {RAMP_STOPS[4][k], 14'd0};
            end else begin
                ramp_chan = acc[18:2];
            end
        end
    endfunction

endpackage
`default_nettype wire

### hdl/clfco_grid_mod.sv
// iterative remainder unit: tests two values for a multiple of the grid spacing
`timescale 1ns / 1ps
`default_nettype none
module clfco_grid_mod (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [12:0]          i_num_a,
    input  wire logic [12:0]          i_num_b,
    input  wire logic [11:0]          i_den,
    output clfco_pkg::t_grid_res      o_res
);
    import clfco_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [3:0]  r_cnt, n_cnt;
    logic [12:0] r_qa, n_qa, r_qb, n_qb;
    logic [12:0] r_ra, n_ra, r_rb, n_rb;
    logic [11:0] r_den, n_den;
    logic [12:0] w_sa, w_sb;

    // one restoring step per cycle on both values
    always_comb begin
        w_sa   = {r_ra[11:0], r_qa[12]};
        w_sb   = {r_rb[11:0], r_qb[12]};
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_qa   = r_qa;
        n_qb   = r_qb;
        n_ra   = r_ra;
        n_rb   = r_rb;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_done = 1'b0;
            n_cnt  = 4'd12;
            n_qa   = i_num_a;
            n_qb   = i_num_b;
            n_ra   = 13'd0;
            n_rb   = 13'd0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_qa = {r_qa[11:0], 1'b0};
            n_qb = {r_qb[11:0], 1'b0};
            n_ra = (w_sa >= {1'b0, r_den}) ? w_sa - {1'b0, r_den} : w_sa;
            n_rb = (w_sb >= {1'b0, r_den}) ? w_sb - {1'b0, r_den} : w_sb;
            n_cnt = r_cnt - 4'd1;
            if (r_cnt == 4'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_qa  <= n_qa;
        r_qb  <= n_qb;
        r_ra  <= n_ra;
        r_rb  <= n_rb;
        r_den <= n_den;
    end

    assign o_res = {r_done, (r_ra == 13'd0), (r_rb == 13'd0)};

endmodule
`default_nettype wire

### hdl/contour_line_false_color_overlay_unit.sv
// top level: contour line and false color overlay decision per pixel
`timescale 1ns / 1ps
`default_nettype none
// Pixels arrive in raster order; each covered pixel gets one overwrite decision
// with its replacement color, one row later, and a row of filler beats after the
// frame flushes the last row. An item passes through accept, multiply, level
// multiply with line store reads, and evaluate with write back; a dark pixel
// under a positive grid spacing also waits while the iterative remainder unit
// tests column and row, and the evaluate step holds while a result waits on a
// stalled receiver. A result waits in an output register while the next pixel is
// taken. Both line stores are MAX_WIDTH deep synchronous memories and need no
// clearing after reset.
module contour_line_false_color_overlay_unit #(
    parameter int MAX_WIDTH  = 4096,
    parameter int LUMA_BITS  = 16,
    parameter int COLOR_BITS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [clfco_pkg::CFG_BITS-1:0] i_cfg_data,
    input  wire logic                   i_in_valid,
    output wire logic                   o_in_stall,
    input  wire logic [LUMA_BITS-1:0]   i_luminance,
    input  wire logic                   i_covered,
    input  wire logic                   i_padding,
    output wire logic                   o_out_valid,
    input  wire logic                   i_out_stall,
    output wire logic                   o_overwrite,
    output wire logic [COLOR_BITS-1:0]  o_red,
    output wire logic [COLOR_BITS-1:0]  o_green,
    output wire logic [COLOR_BITS-1:0]  o_blue,
    output wire logic                   o_frame_done
);
    import clfco_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = AW + 1;
    localparam int PW = LUMA_BITS + 24;
    localparam int OW = NORM_BITS + COLOR_BITS + 1;
    localparam logic [14:0] MAXW15 = 15'(MAX_WIDTH);

    // configuration registers
    logic [12:0] r_frame_width, r_frame_height, r_zero_grid;
    logic [23:0] r_luma_gain;
    logic [8:0]  r_level_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
            r_luma_gain    <= 24'd65536;
            r_level_count  <= 9'd8;
            r_zero_grid    <= 13'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[12:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[12:0];
                REG_LUMA_GAIN:    r_luma_gain    <= i_cfg_data[23:0];
                REG_LEVEL_COUNT:  r_level_count  <= i_cfg_data[8:0];
                REG_ZERO_GRID:    r_zero_grid    <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [14:0]   w_wtmp;
    logic [CW-1:0] w_width;
    logic [12:0]   w_height;
    logic [7:0]    w_lvm1;
    assign w_wtmp   = (r_frame_width == 13'd0) ? 15'd1 :
                      ((15'(r_frame_width) > MAXW15) ? MAXW15 : 15'(r_frame_width));
    assign w_width  = CW'(w_wtmp);
    assign w_height = (r_frame_height == 13'd0) ? 13'd1 : r_frame_height;
    assign w_lvm1   = (r_level_count == 9'd0) ? 8'd0 :
                      ((r_level_count > 9'd256) ? 8'd255 : 8'(r_level_count - 9'd1));

    // control state
    t_state          r_state, n_state;
    logic [AW-1:0]   r_col;
    logic [ROW_BITS-1:0] r_row;
    logic [CODE_BITS-1:0] r_left;
    logic            r_grid_ok;
    // item registers
    logic [LUMA_BITS-1:0] r_lum;
    logic            r_cov, r_flush;
    logic [NORM_BITS-1:0] r_norm;
    logic [CODE_BITS-1:0] r_cur;
    // line stores and read data
    logic [CODE_BITS-1:0] mem_center [0:MAX_WIDTH-1];
    logic [LVL_BITS-1:0]  mem_upper  [0:MAX_WIDTH-1];
    logic [CODE_BITS-1:0] r_rd_c, r_rd_r;
    logic [LVL_BITS-1:0]  r_rd_u;
    // output register
    logic r_out_valid, r_ow, r_fd;
    logic [COLOR_BITS-1:0] r_red, r_green, r_blue;

    t_grid_res w_grid;
    logic w_accept, w_take, w_flush_now, w_commit, w_emit, w_need_grid, w_start;
    logic w_busy, w_rd;

    // column and frame position
    logic [CW-1:0]   w_xp1;
    logic            w_row_end, w_right_in, w_last, w_r1, w_r2;
    logic [AW-1:0]   w_addr1;
    assign w_xp1      = CW'(r_col) + CW'(1);
    assign w_row_end  = (w_xp1 >= w_width);
    assign w_right_in = (w_xp1 < w_width) && (w_xp1 < CW'(MAX_WIDTH));
    assign w_addr1    = w_xp1[AW-1:0];
    assign w_last     = r_flush && w_row_end;
    assign w_r1       = (r_row != '0);
    assign w_r2       = (r_row >= 13'd2);
    assign w_flush_now = (r_row >= w_height);

    // input handshake
    assign w_accept = i_in_valid && !w_busy;
    assign w_take   = w_accept && !(!w_flush_now && i_padding);

    // evaluation of the centre pixel
    logic [CODE_BITS-1:0] w_cen, w_right;
    logic [7:0]  w_mine;
    logic        w_dark, w_cov, w_gpos, w_gzero, w_diff, w_ow;
    logic [NORM_BITS-1:0] w_v;
    assign w_cen   = r_rd_c;
    assign w_right = w_right_in ? r_rd_r : '0;
    assign w_cov   = w_cen[CEN_COV];
    assign w_dark  = w_cen[CEN_DARK];
    assign w_mine  = w_cen[7:0];
    assign w_v     = w_cen[24:8];
    assign w_gzero = (r_zero_grid == 13'd0);
    assign w_gpos  = !r_zero_grid[12] && !w_gzero;

    function automatic logic differs(input logic cov, input logic dark,
                                     input logic [7:0] lvl, input logic [7:0] mine);
        differs = cov && (dark || (lvl != mine));
    endfunction

    always_comb begin
        w_diff = 1'b0;
        if ((r_col != '0) && differs(r_left[CEN_COV], r_left[CEN_DARK], r_left[7:0], w_mine))
            w_diff = 1'b1;
        if (w_right_in && differs(w_right[CEN_COV], w_right[CEN_DARK], w_right[7:0], w_mine))
            w_diff = 1'b1;
        if (w_r2 && differs(r_rd_u[LV_COV], r_rd_u[LV_DARK], r_rd_u[7:0], w_mine))
            w_diff = 1'b1;
        if (differs(r_cur[CEN_COV], r_cur[CEN_DARK], r_cur[7:0], w_mine))
            w_diff = 1'b1;
        if (!w_cov) begin
            w_ow = 1'b0;
        end else if (w_dark) begin
            w_ow = w_gzero || (w_gpos && (w_grid.zero_a || w_grid.zero_b));
        end else begin
            w_ow = w_diff;
        end
    end

    assign w_need_grid = w_r1 && w_cov && w_dark && w_gpos;

    // ramp colors scaled to the output width, rounded half up
    logic [NORM_BITS-1:0] w_c [0:2];
    logic [OW-1:0]        w_s [0:2];
    logic [COLOR_BITS-1:0] w_rgb [0:2];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_c[k]   = ramp_chan(w_v, k);
            w_s[k]   = ({1'b0, w_c[k], {COLOR_BITS{1'b0}}} - OW'(w_c[k])) + OW'(32768);
            w_rgb[k] = (w_ow && !w_dark) ? w_s[k][16 +: COLOR_BITS] : '0;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_take) n_state = S_MUL;
            S_MUL:  n_state = S_LVL;
            S_LVL:  n_state = S_EVAL;
            S_EVAL: begin
                if (w_need_grid && !r_grid_ok) n_state = S_GRID;
                else if (w_commit)             n_state = S_IDLE;
            end
            S_GRID: if (w_grid.done) n_state = S_EVAL;
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        w_busy   = 1'b1;
        w_rd     = 1'b0;
        w_commit = 1'b0;
        w_start  = 1'b0;
        case (r_state)
            S_IDLE: w_busy = 1'b0;
            S_LVL:  w_rd = 1'b1;
            S_EVAL: begin
                w_start  = w_need_grid && !r_grid_ok;
                w_commit = !(w_need_grid && !r_grid_ok) &&
                           (!r_out_valid || !i_out_stall);
            end
            default: ;
        endcase
    end
    assign w_emit     = w_commit && w_r1 && (w_cov || w_last);
    assign o_in_stall = w_busy;

    // grid remainder unit
    clfco_grid_mod u_grid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_num_a (13'(r_col)),
        .i_num_b (r_row - 13'd1),
        .i_den   (r_zero_grid[11:0]),
        .o_res   (w_grid)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_left    <= '0;
            r_grid_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_take) r_grid_ok <= 1'b0;
            else if (r_state == S_GRID && w_grid.done) r_grid_ok <= 1'b1;
            if (w_commit) begin
                if (w_r1) r_left <= w_cen;
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= r_flush ? '0 : r_row + 13'd1;
                end else begin
                    r_col <= w_xp1[AW-1:0];
                end
            end
        end
    end

    // item datapath: luminance gain, then level
    logic [PW-1:0] w_prod;
    logic [24:0]   w_lprod;
    assign w_prod  = PW'(r_lum) * PW'(r_luma_gain);
    assign w_lprod = 25'(w_lvm1) * 25'(r_norm);

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_lum   <= i_luminance;
            r_cov   <= i_covered && !w_flush_now;
            r_flush <= w_flush_now;
        end
        if (r_state == S_MUL) begin
            r_norm <= ((w_prod >> LUMA_BITS) > PW'(65536)) ? 17'h10000 :
                      17'(w_prod >> LUMA_BITS);
        end
        if (r_state == S_LVL) begin
            r_cur <= r_cov ? {1'b1, (r_lum == '0), r_norm, w_lprod[23:16]} : '0;
        end
    end

    // line stores: read in the level cycle, written back at commit
    always_ff @(posedge i_clk) begin
        if (w_rd) begin
            r_rd_c <= mem_center[r_col];
            r_rd_r <= mem_center[w_addr1];
            r_rd_u <= mem_upper[r_col];
        end
        if (w_commit) begin
            mem_center[r_col] <= r_cur;
            if (w_r1) mem_upper[r_col] <= {w_cov, w_dark, w_cen[7:0]};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_emit) begin
            r_ow    <= w_ow;
            r_red   <= w_rgb[0];
            r_green <= w_rgb[1];
            r_blue  <= w_rgb[2];
            r_fd    <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_overwrite  = r_ow;
    assign o_red        = r_red;
    assign o_green      = r_green;
    assign o_blue       = r_blue;
    assign o_frame_done = r_fd;

    // checks
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid) else $error("result beat lost");
    a_grid_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRID) |-> w_gpos) else $error("grid unit run without spacing");
    a_last_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_last) |=> (r_col == '0 && r_row == '0))
        else $error("frame end did not rewind position");
    a_grid_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GRID && w_grid.done) |=> (r_state == S_EVAL && r_grid_ok))
        else $error("grid result not taken");

endmodule
`default_nettype wire
